>>> rtl/hslc_pkg.sv
// Shared types and constants of the HTTP start-line classifier.
package hslc_pkg;

	// Default line limits; the top level takes them as parameters.
	localparam int unsigned FIRST_LINE_MAX_DEF  = 4096;
	localparam int unsigned SECOND_LINE_MAX_DEF = 256;

	// Verdict queue between the scanner and the output stage.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int unsigned FLEN_W   = 12;
	localparam int unsigned CODE_W   = 10;
	localparam int unsigned PREFIX_W = 56;
	localparam int unsigned TAIL_W   = 24;

	// Byte codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// "HTTP" as it shows in a four-byte window, oldest byte highest.
	localparam logic [31:0] WIN_HTTP = 32'h4854_5450;

	// Start-line prefixes, first byte in the low bits.
	localparam logic [31:0] PFX_GET    = 32'h2054_4547;
	localparam logic [31:0] PFX_PUT    = 32'h2054_5550;
	localparam logic [39:0] PFX_HEAD   = 40'h20_4441_4548;
	localparam logic [39:0] PFX_POST   = 40'h20_5453_4F50;
	localparam logic [55:0] PFX_DELETE = 56'h20_4554_454C_4544;
	localparam logic [47:0] PFX_HTTP1  = 48'h312F_5054_5448;

	localparam logic [CODE_W-1:0] CODE_MIN = 10'd100;
	localparam logic [CODE_W-1:0] CODE_MAX = 10'd999;
	localparam logic [CODE_W-1:0] CODE_SAT = 10'd1000;

	typedef enum logic [2:0] {
		VERD_NOT_HTTP  = 3'd0,
		VERD_REQ_SENT  = 3'd1,
		VERD_REQ_RECV  = 3'd2,
		VERD_RESP_SENT = 3'd3,
		VERD_RESP_RECV = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		METH_NONE   = 3'd0,
		METH_GET    = 3'd1,
		METH_PUT    = 3'd2,
		METH_HEAD   = 3'd3,
		METH_POST   = 3'd4,
		METH_DELETE = 3'd5
	} method_t;

	// Line scanner phase.
	typedef enum logic [3:0] {
		PH_FIRST  = 4'b0001,
		PH_SECOND = 4'b0010,
		PH_DONE   = 4'b0100,
		PH_FAIL   = 4'b1000
	} phase_t;

	// Status token parser.
	typedef enum logic [4:0] {
		TK_WAIT  = 5'b00001,
		TK_BLANK = 5'b00010,
		TK_SIGN  = 5'b00100,
		TK_DIGIT = 5'b01000,
		TK_DONE  = 5'b10000
	} token_t;

	// What the scanner knows of one buffer at its last byte.
	typedef struct packed {
		logic                pass;
		logic                is_write;
		logic [PREFIX_W-1:0] prefix;
		logic                code_ok;
		logic [CODE_W-1:0]   code;
		logic [FLEN_W-1:0]   flen;
	} snap_t;

endpackage

>>> rtl/http_start_line_classifier_top.sv
// Top level of the HTTP start-line classifier: scanner, verdict queue and output stage.
//
// Feed the bytes of one buffer, one word per cycle, with last_byte high on the final
// byte; is_write on that final byte picks sent or received. The block takes a byte
// every cycle while in_stall is low and gives exactly one result word per buffer. Its word
// waits in the queue until the output register is free, then shows on out_valid. The scanner
// updates a small running state per byte (line phase, CR tracking, line counters, the
// first seven bytes, a "HTTP" search window and the status-code parser). At the final
// byte it pushes a snapshot into a four-entry queue. The output stage matches the method
// or the "HTTP/1" prefix from that snapshot and holds the result until out_stall drops.
// in_stall rises only when four verdicts wait in the queue, so with a stalled output
// five buffers finish before input stops: one in the output register, four queued.
// Scanning ends after the second CRLF; a NUL, a CR not followed by LF, a CR as the final
// byte, a first line of FIRST_LINE_MAX bytes or a second line of SECOND_LINE_MAX - 1 bytes
// gives not-HTTP. first_line_length is the first line's byte count without CRLF,
// modulo 4096, and zero on a not-HTTP verdict.
module http_start_line_classifier_top #(
	parameter int unsigned FIRST_LINE_MAX  = hslc_pkg::FIRST_LINE_MAX_DEF,
	parameter int unsigned SECOND_LINE_MAX = hslc_pkg::SECOND_LINE_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          is_write,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    verdict,
	output logic [2:0]                    method,
	output logic [hslc_pkg::CODE_W-1:0]   status_code,
	output logic [hslc_pkg::FLEN_W-1:0]   first_line_length
);

	hslc_pkg::snap_t push_data;
	hslc_pkg::snap_t head;
	logic            push;
	logic            full;
	logic            pop;
	logic            empty;

	// Scan bytes; hand one snapshot per buffer to the queue.
	hslc_front #(
		.FIRST_LINE_MAX (FIRST_LINE_MAX),
		.SECOND_LINE_MAX(SECOND_LINE_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.is_write (is_write),
		.last_byte(last_byte),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	// Hold finished snapshots while the output is stalled.
	hslc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	// Classify the head snapshot and present the result word.
	hslc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (empty),
		.q_head           (head),
		.q_pop            (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.verdict          (verdict),
		.method           (method),
		.status_code      (status_code),
		.first_line_length(first_line_length)
	);

endmodule

>>> rtl/hslc_front.sv
// Byte scanner: tracks line state per byte and queues a snapshot at the last byte.
module hslc_front #(
	parameter int unsigned FIRST_LINE_MAX  = hslc_pkg::FIRST_LINE_MAX_DEF,
	parameter int unsigned SECOND_LINE_MAX = hslc_pkg::SECOND_LINE_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               is_write,
	input  logic               last_byte,
	input  logic               q_full,
	output logic               q_push,
	output hslc_pkg::snap_t    q_data
);

	localparam int unsigned CW    = $clog2(FIRST_LINE_MAX + 1);
	localparam int unsigned SW    = $clog2(SECOND_LINE_MAX + 1);
	localparam int unsigned WIDEW = (CW > hslc_pkg::FLEN_W) ? CW : hslc_pkg::FLEN_W;

	hslc_pkg::phase_t                    phase_q, n_phase;
	hslc_pkg::token_t                    tok_q, n_tok;
	logic                                cr_q, n_cr;
	logic [CW-1:0]                       first_q, n_first;
	logic [SW-1:0]                       second_q, n_second;
	logic [hslc_pkg::PREFIX_W-1:0]       prefix_q, n_prefix;
	logic [hslc_pkg::TAIL_W-1:0]         tail_q, n_tail;
	logic                                http_q, n_http;
	logic [hslc_pkg::CODE_W-1:0]         code_q, n_code;
	logic [1:0]                          flags_q, n_flags;

	logic        accept;
	logic        blank;
	logic        digit;
	logic        accum;
	logic [13:0] prod;
	logic [WIDEW-1:0] first_wide;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	assign blank = (data_byte == hslc_pkg::CH_SPACE) || (data_byte == hslc_pkg::CH_TAB) ||
		(data_byte == hslc_pkg::CH_LF) || (data_byte == hslc_pkg::CH_VT) ||
		(data_byte == hslc_pkg::CH_FF);
	assign digit = (data_byte >= hslc_pkg::CH_ZERO) && (data_byte <= hslc_pkg::CH_NINE);
	assign prod  = 14'(code_q) * 14'd10 + 14'(data_byte[3:0]);

	always_comb begin
		n_phase  = phase_q;
		n_tok    = tok_q;
		n_cr     = cr_q;
		n_first  = first_q;
		n_second = second_q;
		n_prefix = prefix_q;
		n_tail   = tail_q;
		n_http   = http_q;
		n_code   = code_q;
		n_flags  = flags_q;
		accum    = 1'b0;
		if ((phase_q == hslc_pkg::PH_FIRST) || (phase_q == hslc_pkg::PH_SECOND)) begin
			if (cr_q) begin
				n_cr = 1'b0;
				if (data_byte != hslc_pkg::CH_LF) begin
					n_phase = hslc_pkg::PH_FAIL;
				end else if (phase_q == hslc_pkg::PH_FIRST) begin
					n_phase  = hslc_pkg::PH_SECOND;
					n_second = second_q + SW'(1);
					if (n_second >= SW'(SECOND_LINE_MAX)) begin
						n_phase = hslc_pkg::PH_FAIL;
					end
				end else begin
					n_phase = hslc_pkg::PH_DONE;
				end
			end else if (data_byte == hslc_pkg::CH_NUL) begin
				n_phase = hslc_pkg::PH_FAIL;
			end else if (data_byte == hslc_pkg::CH_CR) begin
				n_cr = 1'b1;
			end else if (phase_q == hslc_pkg::PH_FIRST) begin
				if ({tail_q, data_byte} == hslc_pkg::WIN_HTTP) begin
					n_http = 1'b1;
				end
				n_tail = {tail_q[15:0], data_byte};
				if (first_q < CW'(7)) begin
					n_prefix[{first_q[2:0], 3'b000} +: 8] = data_byte;
				end
				case (tok_q)
					hslc_pkg::TK_WAIT: begin
						if (blank) begin
							n_tok = hslc_pkg::TK_BLANK;
						end
					end
					hslc_pkg::TK_BLANK: begin
						if (blank) begin
							n_tok = tok_q;
						end else if ((data_byte == hslc_pkg::CH_PLUS) ||
							(data_byte == hslc_pkg::CH_MINUS)) begin
							if (data_byte == hslc_pkg::CH_MINUS) begin
								n_flags[1] = 1'b1;
							end
							n_tok = hslc_pkg::TK_SIGN;
						end else if (!digit) begin
							n_tok = hslc_pkg::TK_DONE;
						end else begin
							accum = 1'b1;
						end
					end
					hslc_pkg::TK_SIGN, hslc_pkg::TK_DIGIT: begin
						if (!digit) begin
							n_tok = hslc_pkg::TK_DONE;
						end else begin
							accum = 1'b1;
						end
					end
					default: begin
						n_tok = tok_q;
					end
				endcase
				if (accum) begin
					n_tok      = hslc_pkg::TK_DIGIT;
					n_flags[0] = 1'b1;
					n_code     = (prod > 14'(hslc_pkg::CODE_MAX)) ? hslc_pkg::CODE_SAT : prod[9:0];
				end
				n_first = first_q + CW'(1);
				if (n_first >= CW'(FIRST_LINE_MAX)) begin
					n_phase = hslc_pkg::PH_FAIL;
				end
			end else begin
				n_second = second_q + SW'(1);
				if (n_second >= SW'(SECOND_LINE_MAX)) begin
					n_phase = hslc_pkg::PH_FAIL;
				end
			end
		end
	end

	assign first_wide = WIDEW'(n_first);

	// Snapshot of the state as it stands after the last byte.
	always_comb begin
		q_data.pass     = (n_phase != hslc_pkg::PH_FAIL) && !n_cr && n_http;
		q_data.is_write = is_write;
		q_data.prefix   = n_prefix;
		q_data.code_ok  = (n_flags == 2'b01) && (n_code >= hslc_pkg::CODE_MIN) &&
			(n_code <= hslc_pkg::CODE_MAX);
		q_data.code     = n_code;
		q_data.flen     = first_wide[hslc_pkg::FLEN_W-1:0];
	end

	assign q_push = accept && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hslc_pkg::PH_FIRST;
			tok_q    <= hslc_pkg::TK_WAIT;
			cr_q     <= 1'b0;
			first_q  <= '0;
			second_q <= '0;
			prefix_q <= '0;
			tail_q   <= '0;
			http_q   <= 1'b0;
			code_q   <= '0;
			flags_q  <= '0;
		end else if (accept) begin
			if (last_byte) begin
				// drop all scan state, ready for the next buffer
				phase_q  <= hslc_pkg::PH_FIRST;
				tok_q    <= hslc_pkg::TK_WAIT;
				cr_q     <= 1'b0;
				first_q  <= '0;
				second_q <= '0;
				prefix_q <= '0;
				tail_q   <= '0;
				http_q   <= 1'b0;
				code_q   <= '0;
				flags_q  <= '0;
			end else begin
				phase_q  <= n_phase;
				tok_q    <= n_tok;
				cr_q     <= n_cr;
				first_q  <= n_first;
				second_q <= n_second;
				prefix_q <= n_prefix;
				tail_q   <= n_tail;
				http_q   <= n_http;
				code_q   <= n_code;
				flags_q  <= n_flags;
			end
		end
	end

endmodule

>>> rtl/hslc_fifo.sv
// Short snapshot queue between the scanner and the output stage.
module hslc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hslc_pkg::snap_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output hslc_pkg::snap_t head
);

	localparam int unsigned AW = hslc_pkg::QUEUE_AW;

	hslc_pkg::snap_t mem_q [hslc_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == (AW + 1)'(hslc_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (AW + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (AW + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/hslc_back.sv
// Verdict stage: matches the start-line prefix and holds the result word.
module hslc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  hslc_pkg::snap_t               q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    verdict,
	output logic [2:0]                    method,
	output logic [hslc_pkg::CODE_W-1:0]   status_code,
	output logic [hslc_pkg::FLEN_W-1:0]   first_line_length
);

	hslc_pkg::method_t            meth_d;
	hslc_pkg::verdict_t           verd_d;
	logic [hslc_pkg::CODE_W-1:0]  code_d;
	logic [hslc_pkg::FLEN_W-1:0]  flen_d;
	logic                         valid_q;
	logic                         load;

	always_comb begin
		meth_d = hslc_pkg::METH_NONE;
		verd_d = hslc_pkg::VERD_NOT_HTTP;
		code_d = '0;
		flen_d = '0;
		if (q_head.pass) begin
			if (q_head.prefix[31:0] == hslc_pkg::PFX_GET) begin
				meth_d = hslc_pkg::METH_GET;
			end else if (q_head.prefix[31:0] == hslc_pkg::PFX_PUT) begin
				meth_d = hslc_pkg::METH_PUT;
			end else if (q_head.prefix[39:0] == hslc_pkg::PFX_HEAD) begin
				meth_d = hslc_pkg::METH_HEAD;
			end else if (q_head.prefix[39:0] == hslc_pkg::PFX_POST) begin
				meth_d = hslc_pkg::METH_POST;
			end else if (q_head.prefix == hslc_pkg::PFX_DELETE) begin
				meth_d = hslc_pkg::METH_DELETE;
			end
			if (meth_d != hslc_pkg::METH_NONE) begin
				verd_d = q_head.is_write ? hslc_pkg::VERD_REQ_SENT : hslc_pkg::VERD_REQ_RECV;
				flen_d = q_head.flen;
			end else if ((q_head.prefix[47:0] == hslc_pkg::PFX_HTTP1) && q_head.code_ok) begin
				verd_d = q_head.is_write ? hslc_pkg::VERD_RESP_SENT : hslc_pkg::VERD_RESP_RECV;
				code_d = q_head.code;
				flen_d = q_head.flen;
			end
		end
	end

	assign load      = !q_empty && (!valid_q || !out_stall);
	assign q_pop     = load;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict           <= verd_d;
			method            <= meth_d;
			status_code       <= code_d;
			first_line_length <= flen_d;
		end
	end

endmodule

>>> rtl/hslc_checker.sv
// Port-level checks of the classifier, bound to the top level.
module hslc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  verdict,
	input logic [2:0]  method,
	input logic [9:0]  status_code,
	input logic [11:0] first_line_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict))
		else $error("result word dropped or changed while stalled");

	a_not_http_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == hslc_pkg::VERD_NOT_HTTP) |->
		(method == hslc_pkg::METH_NONE) && (status_code == '0) && (first_line_length == '0))
		else $error("not-HTTP verdict carries other fields");

	a_request_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((verdict == hslc_pkg::VERD_REQ_SENT) ||
		(verdict == hslc_pkg::VERD_REQ_RECV)) |->
		(method != hslc_pkg::METH_NONE) && (status_code == '0))
		else $error("request verdict without method or with status");

	a_response_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((verdict == hslc_pkg::VERD_RESP_SENT) ||
		(verdict == hslc_pkg::VERD_RESP_RECV)) |->
		(method == hslc_pkg::METH_NONE) && (status_code >= hslc_pkg::CODE_MIN) &&
		(status_code <= hslc_pkg::CODE_MAX))
		else $error("response verdict with bad status code or method");

endmodule

bind http_start_line_classifier_top hslc_checker u_hslc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.verdict          (verdict),
	.method           (method),
	.status_code      (status_code),
	.first_line_length(first_line_length)
);
